[rtl/box_filter_5x5_assert.svh]
// assertion macros shared by the box filter rtl
// expects clk and rst_n in the scope of every use
`ifndef BOX_FILTER_5X5_ASSERT_SVH
`define BOX_FILTER_5X5_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BF5_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BF5_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bf5_pkg.sv]
// shared types and constants of the 5x5 box filter
// no dependencies
`timescale 1ns / 1ps

package bf5_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int ROW_W     = 12;
  localparam int WINDOW    = 5;
  localparam int LINES     = WINDOW - 1;
  localparam int MARGIN2   = 4;   // first row and column with a full window
  localparam int CSUM_W    = 11;  // five pixels
  localparam int WSUM_W    = 13;  // twenty-five pixels
  localparam int RECIP_W   = 14;
  localparam int RECIP_SH  = 18;
  localparam int PROD_W    = WSUM_W + RECIP_W;

  // ceil(2^18 / 25), exact floor division for sums below 8192
  localparam logic [RECIP_W-1:0] RECIP25 = 14'd10486;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [CFG_W-1:0] MIN_DIM    = 12'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t pixel_in;
  } in_word_t;

  typedef struct packed {
    pix_t mean_pixel;
    logic row_end;
    logic frame_end;
  } out_word_t;

  typedef struct packed {
    logic produce;
    logic row_end;
    logic frame_end;
  } tag_t;

  typedef struct packed {
    logic valid;
    tag_t tag;
  } stage_t;

endpackage

[rtl/bf5_stream_if.sv]
// valid/ready stream channel carrying one word per handshake
// word type set by the instantiating scope
`timescale 1ns / 1ps

interface bf5_stream_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/bf5_pos_ctrl.sv]
// frame size registers, column and row counters, result tags
// depends on bf5_pkg and box_filter_5x5_assert.svh
`timescale 1ns / 1ps
`include "box_filter_5x5_assert.svh"

module bf5_pos_ctrl #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bf5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bf5_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           accept,
  output logic [$clog2(MAX_WIDTH)-1:0]   col,
  output bf5_pkg::tag_t                  tag
);
  import bf5_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int EXT_W = 14;
  localparam logic [EXT_W-1:0] MAX_W_EXT = EXT_W'(MAX_WIDTH);

  logic [CFG_W-1:0] width_r, height_r;
  logic [CW-1:0]    col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0]    wm1;
  logic [ROW_W-1:0] hm1;
  logic [EXT_W-1:0] fw_ext;
  logic             last_col, last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective width saturated to 5..MAX_WIDTH, height raised to 5
  assign fw_ext = EXT_W'(width_r);

  always_comb begin
    if (width_r < MIN_DIM) begin
      wm1 = CW'(MIN_DIM - 12'd1);
    end else if (fw_ext > MAX_W_EXT) begin
      wm1 = CW'(MAX_W_EXT - 14'd1);
    end else begin
      wm1 = CW'(fw_ext - 14'd1);
    end
    hm1 = (height_r < MIN_DIM) ? (MIN_DIM - 12'd1) : (height_r - 12'd1);
  end

  assign col      = (col_cnt_r > wm1) ? wm1 : col_cnt_r;
  assign last_col = (col == wm1);
  assign last_row = (row_cnt_r >= hm1);

  assign tag.produce   = (row_cnt_r >= ROW_W'(MARGIN2)) && (col >= CW'(MARGIN2));
  assign tag.row_end   = last_col;
  assign tag.frame_end = last_col && last_row;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (accept) begin
      if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row ? '0 : row_cnt_r + 12'd1;
      end else begin
        col_cnt_nxt = col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  `BF5_ASSERT_NEXT(a_row_hold, accept && !tag.row_end, row_cnt_r == $past(row_cnt_r), "row count moved mid-row")
  `BF5_ASSERT_NEXT(a_col_wrap, accept && tag.row_end, col_cnt_r == '0, "column count did not wrap")
  `BF5_ASSERT_IMP(a_frame_end_row, accept && tag.frame_end, tag.row_end, "frame end off a row end")

endmodule

[rtl/bf5_line_mem.sv]
// line store: one entry per column holding the four rows above
// depends on bf5_pkg
`timescale 1ns / 1ps

module bf5_line_mem #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic                          accept,
  input  logic                          v1,
  input  logic [$clog2(MAX_WIDTH)-1:0]  col,
  input  bf5_pkg::pix_t                 px,
  output logic [bf5_pkg::CSUM_W-1:0]    col_sum
);
  import bf5_pkg::*;

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int ENTRY_W = LINES * PIX_W;

  // oldest row in the top byte, newest in the bottom byte
  logic [ENTRY_W-1:0] mem [MAX_WIDTH];
  logic [ENTRY_W-1:0] rd_r;
  logic [ENTRY_W-1:0] wr_data;
  pix_t               px1_r;
  logic [CW-1:0]      col1_r;
  logic               wr_en;

  assign wr_en   = adv && v1;
  assign wr_data = {rd_r[ENTRY_W-PIX_W-1:0], px1_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[col1_r] <= wr_data;
    end
    if (accept) begin
      // bypass the write-back when the same column is read
      if (wr_en && (col == col1_r)) begin
        rd_r <= wr_data;
      end else begin
        rd_r <= mem[col];
      end
      px1_r  <= px;
      col1_r <= col;
    end
  end

  always_comb begin
    col_sum = CSUM_W'(px1_r);
    for (int k = 0; k < LINES; k++) begin
      col_sum = col_sum + CSUM_W'(rd_r[k*PIX_W +: PIX_W]);
    end
  end

endmodule

[rtl/bf5_win_sum.sv]
// window as five column sums and their registered total
// depends on bf5_pkg
`timescale 1ns / 1ps

module bf5_win_sum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        v1,
  input  logic                        v2,
  input  logic [bf5_pkg::CSUM_W-1:0]  col_sum,
  output logic [bf5_pkg::WSUM_W-1:0]  win_sum
);
  import bf5_pkg::*;

  logic [CSUM_W-1:0] cs_r [WINDOW];
  logic [WSUM_W-1:0] cs_total;
  logic [WSUM_W-1:0] win_sum_r;

  // total of the five columns now in the window; a column that held
  // unfilled line store rows drops out once it shifts past the window
  always_comb begin
    cs_total = '0;
    for (int c = 0; c < WINDOW; c++) begin
      cs_total = cs_total + WSUM_W'(cs_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < WINDOW; c++) begin
        cs_r[c] <= '0;
      end
      win_sum_r <= '0;
    end else if (adv) begin
      if (v1) begin
        for (int c = 0; c < WINDOW - 1; c++) begin
          cs_r[c] <= cs_r[c+1];
        end
        cs_r[WINDOW-1] <= col_sum;
      end
      if (v2) begin
        win_sum_r <= cs_total;
      end
    end
  end

  assign win_sum = win_sum_r;

endmodule

[rtl/bf5_div25.sv]
// divide by 25 via reciprocal multiply, output register and stall control
// depends on bf5_pkg
`timescale 1ns / 1ps

module bf5_div25 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bf5_pkg::stage_t             st3,
  input  bf5_pkg::stage_t             st4,
  input  logic [bf5_pkg::WSUM_W-1:0]  win_sum,
  input  logic                        out_ready,
  output logic                        adv,
  output logic                        out_valid,
  output bf5_pkg::out_word_t          out_word
);
  import bf5_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic              out_valid_r;
  out_word_t         out_word_r;
  logic              load;

  // pipe stops only when a result waits at the end behind a full output
  assign adv  = !(st4.valid && st4.tag.produce && out_valid_r && !out_ready);
  assign load = adv && st4.valid && st4.tag.produce;

  always_ff @(posedge clk) begin
    if (adv && st3.valid) begin
      prod_r <= PROD_W'(win_sum) * PROD_W'(RECIP25);
    end
    if (load) begin
      out_word_r.mean_pixel <= prod_r[RECIP_SH +: PIX_W];
      out_word_r.row_end    <= st4.tag.row_end;
      out_word_r.frame_end  <= st4.tag.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[rtl/box_filter_5x5.sv]
// top level of the streaming 5x5 box (mean) filter
// depends on bf5_pkg, bf5_stream_if, bf5_pos_ctrl, bf5_line_mem, bf5_win_sum, bf5_div25
`timescale 1ns / 1ps
`include "box_filter_5x5_assert.svh"

// usage
//   in_px carries one 8-bit pixel of a padded frame per word, raster order
//   out_px carries the truncated window mean plus row_end and frame_end
//   border centers (first four rows, first four columns) give no word
//   cfg port sets frame width (index 0) and height (index 1); write only
//   while the pipe is empty
// path: a result passes these registers after its pixel is accepted
//   (line store read, column sum, window sum, reciprocal multiply, output reg)
// throughput: one pixel per cycle unless stalled; the line store has one read and one
//   write port per cycle, read-modify-write of the same column is bypassed
// reset: counters at frame start, window sums zero, size 640 x 480; the
//   line store is not cleared, every entry is written before it is used
// stall: when out_ready is low, a held result sits in the output register
//   and the pipe keeps taking pixels until a second result reaches its end;
//   only then does in_px.ready drop
module box_filter_5x5 #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bf5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bf5_pkg::CFG_W-1:0]      cfg_wdata,
  bf5_stream_if.sink                     in_px,
  bf5_stream_if.source                   out_px
);
  import bf5_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int STAGES = 4;

  logic              adv;
  logic              accept;
  logic [CW-1:0]     col;
  tag_t              tag0;
  stage_t            st_r [1:STAGES];
  logic [CSUM_W-1:0] col_sum;
  logic [WSUM_W-1:0] win_sum;
  logic              out_valid;
  out_word_t         out_word;
  in_word_t          in_word;

  assign in_word     = in_px.data;
  assign in_px.ready = adv;
  assign accept      = in_px.valid && adv;

  // position, frame size and result tags of the incoming pixel
  bf5_pos_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .col       (col),
    .tag       (tag0)
  );

  // valid and tag travel beside the data, all stages move together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= STAGES; i++) begin
        st_r[i] <= '0;
      end
    end else if (adv) begin
      st_r[1].valid <= accept;
      st_r[1].tag   <= tag0;
      for (int i = 2; i <= STAGES; i++) begin
        st_r[i] <= st_r[i-1];
      end
    end
  end

  // stage 1: line store read at accept, rotate and write back
  bf5_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line (
    .clk     (clk),
    .adv     (adv),
    .accept  (accept),
    .v1      (st_r[1].valid),
    .col     (col),
    .px      (in_word.pixel_in),
    .col_sum (col_sum)
  );

  // stages 2 and 3: column sums shift, window sum
  bf5_win_sum u_win (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .v1      (st_r[1].valid),
    .v2      (st_r[2].valid),
    .col_sum (col_sum),
    .win_sum (win_sum)
  );

  // stage 4 and output: divide by 25, output register
  bf5_div25 u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .st3       (st_r[3]),
    .st4       (st_r[4]),
    .win_sum   (win_sum),
    .out_ready (out_px.ready),
    .adv       (adv),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  assign out_px.valid = out_valid;
  assign out_px.data  = out_word;

  `BF5_ASSERT_IMP(a_stall_cause, !adv, out_valid && !out_px.ready, "stall without a held result")
  `BF5_ASSERT_NEXT(a_result_lands, adv && st_r[STAGES].valid && st_r[STAGES].tag.produce, out_valid, "result lost at output")
  `BF5_ASSERT_NEXT(a_out_hold, out_valid && !out_px.ready, out_valid && $stable(out_word), "held word changed")

endmodule

[tb/sv/box_filter_5x5_tb.sv]
// self-checking testbench for the streaming 5x5 box filter: random pixel frames go in,
// window means come out and are compared with a cycle-free software copy of the filter
// depends on bf5_pkg, bf5_stream_if and box_filter_5x5 from the rtl
`timescale 1ns / 1ps

module box_filter_5x5_tb;
  import bf5_pkg::*;

  localparam int          CLK_PERIOD    = 10;
  localparam int          MAX_W         = 2048;
  localparam int unsigned AREA          = WINDOW * WINDOW;
  localparam int unsigned RANDOM_PIXELS = 1200;
  // pipe is 4 deep; border pixels may still be in flight after the last mean
  localparam int          DRAIN_CYCLES  = 12;
  localparam int          TIMEOUT_NS    = 50_000_000;

  // pixel content of one burst of stimulus
  typedef enum {
    TEX_UNIFORM,
    TEX_BLACK,
    TEX_WHITE,
    TEX_DARK,
    TEX_BRIGHT
  } texture_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  bf5_stream_if #(.word_t(in_word_t))  pixel_if ();
  bf5_stream_if #(.word_t(out_word_t)) mean_if ();

  box_filter_5x5 #(.MAX_WIDTH(MAX_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_px     (pixel_if),
    .out_px    (mean_if)
  );

  // software copy of the filter state
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  pix_t             line_mem [MAX_W*LINES];
  int unsigned      line_writes [MAX_W];   // writes per column, saturates at LINES
  pix_t             win [WINDOW][WINDOW];  // [column][row], column 0 oldest
  int unsigned      col_cnt;
  int unsigned      row_cnt;

  pix_t        pixel_q [$];   // pixels waiting for the driver
  out_word_t   mean_q [$];    // means still owed by the block
  out_word_t   want_word;
  int unsigned mismatch_cnt = 0;
  int unsigned pixels_sent  = 0;
  int unsigned in_gap       = 0;
  int unsigned in_burst     = 0;
  int unsigned out_stall    = 0;
  int unsigned out_burst    = 0;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // frame size as the block sees it: width clamped to 5..MAX_W, height raised to 5
  function automatic int unsigned eff_width(input logic [CFG_W-1:0] v);
    if (v < MIN_DIM) return 32'(MIN_DIM);
    if (v > MAX_W) return MAX_W;
    return 32'(v);
  endfunction

  function automatic int unsigned eff_height(input logic [CFG_W-1:0] v);
    return 32'((v < MIN_DIM) ? MIN_DIM : v);
  endfunction

  // push one accepted pixel through the filter copy, queue a mean when a full
  // interior window is present
  function automatic void filter_pixel(input pix_t px);
    int unsigned w, h, c, base, sum;
    pix_t        col_px [WINDOW];
    out_word_t   res;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    // a column count left beyond a narrowed width lands on the last column
    c = (col_cnt >= w) ? w - 1 : col_cnt;
    base = c * LINES;
    for (int k = 0; k < LINES; k++) col_px[k] = line_mem[base + k];
    col_px[LINES] = px;
    // line store keeps the four most recent rows of this column
    for (int k = 0; k < LINES; k++) line_mem[base + k] = col_px[k + 1];
    if (line_writes[c] < LINES) line_writes[c]++;
    for (int x = 0; x < WINDOW - 1; x++)
      for (int y = 0; y < WINDOW; y++) win[x][y] = win[x + 1][y];
    for (int y = 0; y < WINDOW; y++) win[WINDOW - 1][y] = col_px[y];
    if (row_cnt >= MARGIN2 && c >= MARGIN2) begin
      sum = 0;
      for (int x = 0; x < WINDOW; x++)
        for (int y = 0; y < WINDOW; y++) sum += win[x][y];
      res.mean_pixel = pix_t'(sum / AREA);
      res.row_end    = (c >= w - 1);
      res.frame_end  = res.row_end && (row_cnt >= h - 1);
      mean_q = {mean_q, res};
    end
    // row and frame wrap
    if (c >= w - 1) begin
      col_cnt = 0;
      row_cnt = (row_cnt >= h - 1) ? 0 : (row_cnt + 1) % (1 << ROW_W);
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  // leading columns whose four line store rows all hold written pixels
  function automatic int unsigned primed_width();
    int unsigned n;
    n = 0;
    while (n < MAX_W && line_writes[n] >= LINES) n++;
    return n;
  endfunction

  function automatic int unsigned pixels_to_frame_end();
    int unsigned w, h, rows_left, cols_left;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    if (col_cnt == 0 && row_cnt == 0) return 0;
    rows_left = (row_cnt >= h - 1) ? 0 : h - 1 - row_cnt;
    cols_left = (col_cnt >= w - 1) ? 1 : w - col_cnt;
    return rows_left * w + cols_left;
  endfunction

  function automatic pix_t next_pixel(input texture_t tex);
    case (tex)
      TEX_BLACK:  return '0;
      TEX_WHITE:  return '1;
      TEX_DARK:   return pix_t'($urandom_range(0, 15));
      TEX_BRIGHT: return pix_t'($urandom_range(240, 255));
      default:    return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic texture_t pick_texture();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return TEX_UNIFORM;
    if (r < 14) return TEX_BLACK;
    if (r < 16) return TEX_WHITE;
    if (r < 18) return TEX_DARK;
    return TEX_BRIGHT;
  endfunction

  // idle cycles before the next word: mostly none or short, a few long,
  // now and then a long burst with no idling at all
  function automatic int unsigned pick_idle(inout int unsigned burst);
    int unsigned r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      burst = $urandom_range(30, 300);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // register write; only called with the pipe empty
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  // hand n pixels to the driver, then hold off until every mean is back
  task automatic stream_pixels(input int unsigned n, input texture_t tex);
    for (int unsigned i = 0; i < n; i++) pixel_q = {pixel_q, next_pixel(tex)};
    pixels_sent += n;
    do @(negedge clk);
    while (pixel_q.size() != 0 || pixel_if.valid || mean_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // driver: one pixel word per handshake, random gaps between words
  always @(posedge clk) begin
    if (!rst_n) begin
      pixel_if.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (pixel_if.valid && pixel_if.ready) filter_pixel(pixel_if.data.pixel_in);
      if (!pixel_if.valid || pixel_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          pixel_if.valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          pixel_if.data.pixel_in <= pixel_q.pop_front();
          pixel_if.valid         <= 1'b1;
          in_gap = pick_idle(in_burst);
        end else begin
          pixel_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, each mean word checked against the oldest owed one
  always @(posedge clk) begin
    if (!rst_n) begin
      mean_if.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (mean_if.valid && mean_if.ready) begin
        if (mean_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got mean %0d row_end %0b frame_end %0b",
                   $time, mean_if.data.mean_pixel, mean_if.data.row_end,
                   mean_if.data.frame_end);
          mismatch_cnt++;
        end else begin
          want_word = mean_q.pop_front();
          if (mean_if.data !== want_word) begin
            $display("%0t: mismatch (mean/row_end/frame_end), expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     $time, want_word.mean_pixel, want_word.row_end, want_word.frame_end,
                     mean_if.data.mean_pixel, mean_if.data.row_end, mean_if.data.frame_end);
            mismatch_cnt++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        mean_if.ready <= 1'b0;
      end else begin
        mean_if.ready <= 1'b1;
        out_stall = pick_idle(out_burst);
      end
    end
  end

  initial begin
    int unsigned      start;
    int unsigned      kind;
    texture_t         tex;
    logic [CFG_W-1:0] new_w;
    logic [CFG_W-1:0] new_h;

    // every block input known from time zero
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    pixel_if.valid = 1'b0;
    pixel_if.data  = '0;
    mean_if.ready  = 1'b0;

    // filter copy in its reset state
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    col_cnt    = 0;
    row_cnt    = 0;
    for (int i = 0; i < MAX_W * LINES; i++) line_mem[i] = '0;
    for (int i = 0; i < MAX_W; i++) line_writes[i] = 0;
    for (int x = 0; x < WINDOW; x++)
      for (int y = 0; y < WINDOW; y++) win[x][y] = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: a few pixels at the reset size, then both registers below
    // range (5 x 5 frame); the column count is past the new width, so the
    // next pixel closes row 0; all-white frame gives a mean of 255 with
    // both end flags
    stream_pixels(6, TEX_WHITE);
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    stream_pixels(21, TEX_WHITE);

    // width above range saturates to the widest line; a short run at the
    // start of a frame, then the width drops below the column count and the
    // frame is finished six pixels wide
    write_reg(REG_FRAME_WIDTH, '1);
    write_reg(REG_FRAME_HEIGHT, 12'd5);
    stream_pixels(8, TEX_UNIFORM);
    write_reg(REG_FRAME_WIDTH, 12'd6);
    stream_pixels(pixels_to_frame_end(), TEX_UNIFORM);

    // tallest frame, cut short mid-frame by a height below the current row
    write_reg(REG_FRAME_WIDTH, 12'd6);
    write_reg(REG_FRAME_HEIGHT, '1);
    stream_pixels(6 * 7 + 3, pick_texture());
    write_reg(REG_FRAME_HEIGHT, 12'd6);
    stream_pixels(pixels_to_frame_end(), pick_texture());

    // random part: mostly whole small frames, some size changes mid-frame
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      kind = $urandom_range(0, 9);
      tex  = pick_texture();
      if (kind < 6) begin
        stream_pixels(pixels_to_frame_end(), tex);
        new_w = CFG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                                   : $urandom_range(5, 16));
        new_h = CFG_W'($urandom_range(5, 10));
        write_reg(REG_FRAME_WIDTH, new_w);
        write_reg(REG_FRAME_HEIGHT, new_h);
        stream_pixels(new_w * new_h * $urandom_range(1, 3), tex);
      end else if (kind < 8) begin
        // mid-frame widening only over columns the line store already holds
        new_w = CFG_W'($urandom_range(0, 40));
        if ((col_cnt != 0 || row_cnt != 0) && eff_width(new_w) > primed_width())
          new_w = width_reg;
        write_reg(REG_FRAME_WIDTH, new_w);
        stream_pixels($urandom_range(1, 3 * eff_width(new_w)), tex);
      end else begin
        new_h = CFG_W'($urandom_range(0, 12));
        write_reg(REG_FRAME_HEIGHT, new_h);
        stream_pixels($urandom_range(1, 3 * eff_width(width_reg)), tex);
      end
    end

    if (mismatch_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/bf5_pkg.sv
rtl/bf5_stream_if.sv
rtl/bf5_pos_ctrl.sv
rtl/bf5_line_mem.sv
rtl/bf5_win_sum.sv
rtl/bf5_div25.sv
rtl/box_filter_5x5.sv
tb/sv/box_filter_5x5_tb.sv
